@@ hw/rtl/epoch_to_calendar_date_macros.svh @@
// ---------------------------------------------------------------------------
// epoch_to_calendar_date assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef EPOCH_TO_CALENDAR_DATE_MACROS_SVH
`define EPOCH_TO_CALENDAR_DATE_MACROS_SVH

// checked on every clock edge outside reset
`define ETCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define ETCD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/etcd_pkg.sv @@
// ---------------------------------------------------------------------------
// etcd_pkg
// types, constants and calendar helpers for the epoch to date converter
// ---------------------------------------------------------------------------
`default_nettype none

package etcd_pkg;

    // datapath widths
    localparam int DIV_W  = 32;                 // dividend and quotient
    localparam int DVS_W  = 6;                  // divisor and remainder
    localparam int PROD_W = 2 * DIV_W;          // shared multiplier product
    localparam int DAYS_W = 16;                 // whole days, at most 49710
    localparam int LEN_W  = 9;                  // year or month length
    localparam int YEAR_W = 12;

    // constant divisors
    localparam logic [DVS_W-1:0] SEC_PER_MIN  = 6'd60;
    localparam logic [DVS_W-1:0] MIN_PER_HOUR = 6'd60;
    localparam logic [DVS_W-1:0] HOUR_PER_DAY = 6'd24;
    localparam logic [DVS_W-1:0] DAY_PER_WEEK = 6'd7;

    // scaled reciprocals, exact over the dividend range of each divisor
    localparam logic [DIV_W-1:0] RECIP_60 = 32'h8888_8889;   // any 32-bit value
    localparam logic [DIV_W-1:0] RECIP_24 = 32'hAAAA_AAAB;   // any 32-bit value
    localparam logic [DIV_W-1:0] RECIP_7  = 32'h2492_4925;   // below 2^32 / 3
    localparam int               SHIFT_60 = 37;
    localparam int               SHIFT_24 = 36;
    localparam int               SHIFT_7  = 32;

    // day zero is a thursday
    localparam logic [DIV_W-1:0] WEEKDAY_OFS = 32'd4;

    // calendar constants
    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
    localparam logic [6:0]        EPOCH_C100 = 7'd70;   // 1970 mod 100
    localparam logic [8:0]        EPOCH_C400 = 9'd370;  // 1970 mod 400
    localparam logic [6:0]        LAST_C100  = 7'd99;
    localparam logic [8:0]        LAST_C400  = 9'd399;
    localparam logic [LEN_W-1:0]  DAYS_LEAP  = 9'd366;
    localparam logic [LEN_W-1:0]  DAYS_YEAR  = 9'd365;
    localparam logic [3:0]        DECEMBER   = 4'd12;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

    // calendar walk request and response
    typedef struct packed {
        logic              start;
        logic [DAYS_W-1:0] days;
    } t_walk_req;

    typedef struct packed {
        logic              done;
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
    } t_walk_rsp;

    // length of a month, february taking the leap flag
    function automatic logic [LEN_W-1:0] month_days(input logic [3:0] m, input logic leap);
        logic [LEN_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 9'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 9'd30;
            4'd2:                                       len = leap ? 9'd29 : 9'd28;
            default:                                    len = 9'd30;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/etcd_div.sv @@
// ---------------------------------------------------------------------------
// etcd_div
// division by a constant divisor through its reciprocal on a shared multiplier
// ---------------------------------------------------------------------------
`default_nettype none

module etcd_div
    import etcd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_QUO,
        S_QUO,
        S_MUL_REM,
        S_REM
    } t_state;

    t_state            r_state;
    logic [DIV_W-1:0]  r_num;
    logic [DVS_W-1:0]  r_dvs;
    logic [PROD_W-1:0] r_prod;
    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic              r_done;

    logic [DIV_W-1:0]  w_recip;
    logic [DIV_W-1:0]  w_quo;
    logic [DIV_W-1:0]  w_mul_a;
    logic [DIV_W-1:0]  w_mul_b;
    logic [PROD_W-1:0] w_prod;

    // reciprocal and quotient scaling for the requested divisor
    always_comb begin
        case (r_dvs)
            HOUR_PER_DAY: begin
                w_recip = RECIP_24;
                w_quo   = DIV_W'(r_prod >> SHIFT_24);
            end
            DAY_PER_WEEK: begin
                w_recip = RECIP_7;
                w_quo   = DIV_W'(r_prod >> SHIFT_7);
            end
            default: begin
                // sixty seconds or sixty minutes
                w_recip = RECIP_60;
                w_quo   = DIV_W'(r_prod >> SHIFT_60);
            end
        endcase
    end

    // shared multiplier: dividend times reciprocal, then quotient times divisor
    assign w_mul_a = (r_state == S_MUL_QUO) ? r_num : r_quo;
    assign w_mul_b = (r_state == S_MUL_QUO) ? w_recip : {{(DIV_W - DVS_W){1'b0}}, r_dvs};
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // sequencer and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_num   <= i_req.dividend;
                        r_dvs   <= i_req.divisor;
                        r_state <= S_MUL_QUO;
                    end
                end
                S_MUL_QUO: begin
                    r_prod  <= w_prod;
                    r_state <= S_QUO;
                end
                S_QUO: begin
                    r_quo   <= w_quo;
                    r_state <= S_MUL_REM;
                end
                S_MUL_REM: begin
                    r_prod  <= w_prod;
                    r_state <= S_REM;
                end
                S_REM: begin
                    // remainder is below the divisor, so the low bits suffice
                    r_rem   <= r_num[DVS_W-1:0] - r_prod[DVS_W-1:0];
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

@@ hw/rtl/etcd_walk.sv @@
// ---------------------------------------------------------------------------
// etcd_walk
// year and month walk, one whole year or month taken off per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module etcd_walk
    import etcd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_walk_req i_req,
    output t_walk_rsp      o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_YEAR,
        S_MONTH
    } t_state;

    t_state            r_state;
    logic [DAYS_W-1:0] r_days;
    logic [YEAR_W-1:0] r_year;
    logic [6:0]        r_c100;
    logic [8:0]        r_c400;
    logic [3:0]        r_month;
    logic [4:0]        r_day;
    logic              r_done;

    logic              w_leap;
    logic [LEN_W-1:0]  w_len;
    logic [DAYS_W:0]   w_diff;
    logic              w_fits;

    // full leap rule from the mod 4, mod 100 and mod 400 positions
    assign w_leap = (r_year[1:0] == 2'b00) && ((r_c100 != 7'd0) || (r_c400 == 9'd0));

    // shared compare and subtract of one year or one month
    assign w_len  = (r_state == S_YEAR) ? (w_leap ? DAYS_LEAP : DAYS_YEAR)
                                        : month_days(r_month, w_leap);
    assign w_diff = {1'b0, r_days} - {{(DAYS_W + 1 - LEN_W){1'b0}}, w_len};
    assign w_fits = !w_diff[DAYS_W];

    // sequencer and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_days  <= i_req.days;
                        r_year  <= EPOCH_YEAR;
                        r_c100  <= EPOCH_C100;
                        r_c400  <= EPOCH_C400;
                        r_month <= 4'd1;
                        r_state <= S_YEAR;
                    end
                end
                S_YEAR: begin
                    if (w_fits) begin
                        r_days <= w_diff[DAYS_W-1:0];
                        r_year <= r_year + 1'b1;
                        r_c100 <= (r_c100 == LAST_C100) ? 7'd0 : r_c100 + 1'b1;
                        r_c400 <= (r_c400 == LAST_C400) ? 9'd0 : r_c400 + 1'b1;
                    end else begin
                        r_state <= S_MONTH;
                    end
                end
                S_MONTH: begin
                    if ((r_month < DECEMBER) && w_fits) begin
                        r_days  <= w_diff[DAYS_W-1:0];
                        r_month <= r_month + 1'b1;
                    end else begin
                        r_day   <= r_days[4:0] + 5'd1;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.year  = r_year;
    assign o_rsp.month = r_month;
    assign o_rsp.day   = r_day;

endmodule

`default_nettype wire

@@ hw/rtl/epoch_to_calendar_date.sv @@
// ---------------------------------------------------------------------------
// epoch_to_calendar_date
// converts unsigned seconds since 1970-01-01 00:00:00 to calendar fields
// ---------------------------------------------------------------------------
// usage:
//   a command transfer happens at a clock edge with i_start high and o_busy
//   low; i_epoch_seconds is sampled at that edge. o_busy stays high while the
//   conversion runs.
//   the result appears on o_second .. o_day for exactly one cycle with
//   o_valid high; the receiver cannot stall, so it must take it then. o_busy
//   is already low in that cycle, so a new command may be issued alongside.
// sequence:
//   four passes through the shared reciprocal divider (/60, /60, /24 and the
//   weekday /7) run one after another, then the calendar walk takes off one
//   whole year past 1970 per step and then one month past january per step.
//   the result strobe is raised once the walk is done. one conversion is in
//   flight at a time; a new command can be taken in the strobe cycle.
// reset:
//   i_rst_n low at a clock edge abandons any conversion, clears o_busy and
//   o_valid; only the sequencers and strobes are reset, not the data registers.
// ---------------------------------------------------------------------------
`default_nettype none

module epoch_to_calendar_date
    import etcd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_epoch_seconds,
    output logic             o_busy,
    output logic             o_valid,
    output logic [5:0]       o_second,
    output logic [5:0]       o_minute,
    output logic [4:0]       o_hour,
    output logic [2:0]       o_weekday,
    output logic [11:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEC,
        S_MIN,
        S_HOUR,
        S_WDAY,
        S_WALK
    } t_state;

    t_state    r_state;
    t_div_req  r_div_req;
    t_walk_req r_walk_req;
    t_div_rsp  w_div_rsp;
    t_walk_rsp w_walk_rsp;
    logic      w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    // shared divider
    etcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_div_rsp)
    );

    // year and month walk
    etcd_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_walk_req),
        .o_rsp   (w_walk_rsp)
    );

    // top sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_div_req.start  <= 1'b0;
            r_walk_req.start <= 1'b0;
            o_valid          <= 1'b0;
        end else begin
            r_div_req.start  <= 1'b0;
            r_walk_req.start <= 1'b0;
            o_valid          <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= i_epoch_seconds;
                        r_div_req.divisor  <= SEC_PER_MIN;
                        r_state            <= S_SEC;
                    end
                end
                S_SEC: begin
                    if (w_div_rsp.done) begin
                        o_second           <= w_div_rsp.rem;
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= w_div_rsp.quo;
                        r_div_req.divisor  <= MIN_PER_HOUR;
                        r_state            <= S_MIN;
                    end
                end
                S_MIN: begin
                    if (w_div_rsp.done) begin
                        o_minute           <= w_div_rsp.rem;
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= w_div_rsp.quo;
                        r_div_req.divisor  <= HOUR_PER_DAY;
                        r_state            <= S_HOUR;
                    end
                end
                S_HOUR: begin
                    // whole days feed both the weekday and the walk
                    if (w_div_rsp.done) begin
                        o_hour             <= w_div_rsp.rem[4:0];
                        r_walk_req.days    <= w_div_rsp.quo[DAYS_W-1:0];
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= w_div_rsp.quo + WEEKDAY_OFS;
                        r_div_req.divisor  <= DAY_PER_WEEK;
                        r_state            <= S_WDAY;
                    end
                end
                S_WDAY: begin
                    if (w_div_rsp.done) begin
                        o_weekday        <= w_div_rsp.rem[2:0];
                        r_walk_req.start <= 1'b1;
                        r_state          <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (w_walk_rsp.done) begin
                        o_year  <= w_walk_rsp.year;
                        o_month <= w_walk_rsp.month;
                        o_day   <= w_walk_rsp.day;
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/etcd_checker.sv @@
// ---------------------------------------------------------------------------
// etcd_checker
// port-level checks on the command and result transfers
// ---------------------------------------------------------------------------
`default_nettype none

`include "epoch_to_calendar_date_macros.svh"

module etcd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        o_busy,
    input wire logic        o_valid,
    input wire logic [5:0]  o_second,
    input wire logic [5:0]  o_minute,
    input wire logic [4:0]  o_hour,
    input wire logic [2:0]  o_weekday,
    input wire logic [11:0] o_year,
    input wire logic [3:0]  o_month,
    input wire logic [4:0]  o_day
);

    logic w_time_ok;
    logic w_date_ok;

    // field range terms
    assign w_time_ok = (o_second < 6'd60) && (o_minute < 6'd60) && (o_hour < 5'd24)
                    && (o_weekday < 3'd7);
    assign w_date_ok = (o_year >= 12'd1970) && (o_year <= 12'd2106) && (o_month >= 4'd1)
                    && (o_month <= 4'd12) && (o_day >= 5'd1);

    // a command transfer always starts a conversion
    `ETCD_ASSERT(a_accept_busy, (i_start && !o_busy) |=> o_busy, "accepted command did not raise busy")

    // one strobe per result
    `ETCD_ASSERT(a_single_strobe, o_valid |=> !o_valid, "result strobe held for more than one cycle")

    // time of day fields in range
    `ETCD_ASSERT(a_time_range, o_valid |-> w_time_ok, "time of day field out of range")

    // date fields in range
    `ETCD_ASSERT(a_date_range, o_valid |-> w_date_ok, "date field out of range")

    // reset leaves the block idle with no result
    `ETCD_ASSERT_RST(a_reset_idle, !i_rst_n |=> !o_busy && !o_valid, "block not idle after reset")

endmodule

bind epoch_to_calendar_date etcd_checker u_etcd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (i_start),
    .o_busy    (o_busy),
    .o_valid   (o_valid),
    .o_second  (o_second),
    .o_minute  (o_minute),
    .o_hour    (o_hour),
    .o_weekday (o_weekday),
    .o_year    (o_year),
    .o_month   (o_month),
    .o_day     (o_day)
);

`default_nettype wire
